/* src/buzzer_alert_sequencer_assert.svh */
// Assertion macros used by the checker file.
`ifndef BUZZER_ALERT_SEQUENCER_ASSERT_SVH
`define BUZZER_ALERT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define BAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define BAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define BAS_ASSERT_NXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/bas_pkg.sv */
// ----------------------------------------------------------------------------
// bas_pkg
// Types and constants of the buzzer alert sequencer.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam int CfgWidth   = 16;
    localparam int CfgIdxW    = 3;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_SHORT_BEEP   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CONFIRM_BEEP = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SEGMENT      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PAUSE        = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_REPEATS      = 3'd4;

    // register reset values
    localparam logic [7:0]  RST_SHORT_BEEP   = 8'd2;
    localparam logic [7:0]  RST_CONFIRM_BEEP = 8'd100;
    localparam logic [15:0] RST_SEGMENT      = 16'd80;
    localparam logic [15:0] RST_PAUSE        = 16'd850;
    localparam logic [3:0]  RST_REPEATS      = 4'd3;

    // tone codes
    localparam logic [1:0] TONE_4K0 = 2'd0;
    localparam logic [1:0] TONE_4K1 = 2'd1;
    localparam logic [1:0] TONE_2K0 = 2'd2;
    localparam logic [1:0] TONE_3K3 = 2'd3;

    // alarm phases
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_TONE1 = 4'd1;
    localparam logic [3:0] PH_GAP1  = 4'd2;
    localparam logic [3:0] PH_TONE2 = 4'd3;
    localparam logic [3:0] PH_GAP2  = 4'd4;
    localparam logic [3:0] PH_TONE3 = 4'd5;
    localparam logic [3:0] PH_GAP3  = 4'd6;
    localparam logic [3:0] PH_TONE4 = 4'd7;
    localparam logic [3:0] PH_PAUSE = 4'd8;

    typedef struct packed {
        logic [7:0]  short_beep_ticks;
        logic [7:0]  confirm_beep_ticks;
        logic [15:0] segment_ticks;
        logic [15:0] pause_ticks;
        logic [3:0]  alarm_repeats;
    } cfg_t;

    typedef struct packed {
        logic        short_beep_pending;
        logic        confirm_beep_pending;
        logic        low_battery_latched;
        logic        all_off_pending;
        logic [7:0]  beep_counter;
        logic [7:0]  all_off_counter;
        logic [3:0]  alarm_phase;
        logic [15:0] alarm_counter;
        logic [3:0]  alarm_cycles;
        logic        drive_on;
        logic [1:0]  drive_tone;
    } state_t;

    typedef struct packed {
        logic request_short_beep;
        logic request_confirm_beep;
        logic test_tone_active;
        logic request_low_battery;
        logic request_all_off_beep;
        logic burner_active;
    } tick_t;

endpackage

/* src/bas_core.sv */
// ----------------------------------------------------------------------------
// bas_core
// Next-state and result logic for one tick of the alert sequencer.
// ----------------------------------------------------------------------------
module bas_core
    import bas_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t cur,
    input  tick_t  tick,
    output state_t nxt,
    output logic   clear_pulse
);

    state_t      s;
    logic [7:0]  beep_inc;
    logic [7:0]  alloff_inc;
    logic [15:0] alarm_inc;
    logic [3:0]  cycles_inc;
    logic        seg_done;

    assign beep_inc   = cur.beep_counter + 8'd1;
    assign alloff_inc = cur.all_off_counter + 8'd1;
    assign alarm_inc  = cur.alarm_counter + 16'd1;
    assign cycles_inc = cur.alarm_cycles + 4'd1;
    assign seg_done   = (alarm_inc >= cfg.segment_ticks);

    always_comb begin
        s           = cur;
        clear_pulse = 1'b0;
        // latch request pulses before service
        s.short_beep_pending   = cur.short_beep_pending | tick.request_short_beep;
        s.confirm_beep_pending = cur.confirm_beep_pending | tick.request_confirm_beep;
        s.low_battery_latched  = cur.low_battery_latched | tick.request_low_battery;
        s.all_off_pending      = cur.all_off_pending | tick.request_all_off_beep;

        if (s.short_beep_pending) begin
            if (cur.beep_counter == 8'd0) begin
                s.drive_on   = 1'b1;
                s.drive_tone = TONE_4K0;
            end
            s.beep_counter = beep_inc;
            if (beep_inc > cfg.short_beep_ticks) begin
                s.beep_counter       = 8'd0;
                s.drive_on           = 1'b0;
                s.short_beep_pending = 1'b0;
            end
        end else if (s.confirm_beep_pending) begin
            if (cur.beep_counter == 8'd0) begin
                s.drive_on   = 1'b1;
                s.drive_tone = TONE_4K1;
            end
            s.beep_counter = beep_inc;
            if (beep_inc > cfg.confirm_beep_ticks) begin
                s.beep_counter         = 8'd0;
                s.drive_on             = 1'b0;
                s.confirm_beep_pending = 1'b0;
            end
        end else if (tick.test_tone_active) begin
            s.drive_on   = 1'b1;
            s.drive_tone = TONE_4K1;
        end else if (s.low_battery_latched) begin
            case (cur.alarm_phase)
                PH_START: begin
                    s.drive_on      = 1'b1;
                    s.drive_tone    = TONE_2K0;
                    s.alarm_phase   = PH_TONE1;
                    s.alarm_counter = 16'd0;
                end
                PH_TONE1, PH_TONE2, PH_TONE3, PH_TONE4: begin
                    s.alarm_counter = seg_done ? 16'd0 : alarm_inc;
                    if (seg_done) begin
                        s.drive_on    = 1'b0;
                        s.alarm_phase = cur.alarm_phase + 4'd1;
                    end
                end
                PH_GAP1, PH_GAP3: begin
                    s.alarm_counter = seg_done ? 16'd0 : alarm_inc;
                    if (seg_done) begin
                        s.drive_on    = 1'b1;
                        s.drive_tone  = TONE_3K3;
                        s.alarm_phase = cur.alarm_phase + 4'd1;
                    end
                end
                PH_GAP2: begin
                    s.alarm_counter = seg_done ? 16'd0 : alarm_inc;
                    if (seg_done) begin
                        s.drive_on    = 1'b1;
                        s.drive_tone  = TONE_4K1;
                        s.alarm_phase = PH_TONE3;
                    end
                end
                PH_PAUSE: begin
                    s.alarm_counter = alarm_inc;
                    if (alarm_inc > cfg.pause_ticks) begin
                        s.alarm_counter = 16'd0;
                        s.alarm_phase   = PH_START;
                        s.alarm_cycles  = cycles_inc;
                        if (cycles_inc > cfg.alarm_repeats) begin
                            s.alarm_cycles        = 4'd0;
                            clear_pulse           = tick.burner_active;
                            s.low_battery_latched = 1'b0;
                        end
                    end
                end
                default: begin
                    // unreachable phases: hold until idle resets them
                end
            endcase
        end else if (s.all_off_pending) begin
            if (cur.all_off_counter == 8'd0) begin
                s.drive_on   = 1'b1;
                s.drive_tone = TONE_4K1;
            end
            s.all_off_counter = alloff_inc;
            if (alloff_inc > cfg.confirm_beep_ticks) begin
                s.all_off_counter = 8'd0;
                s.drive_on        = 1'b0;
                s.all_off_pending = 1'b0;
            end
        end else begin
            s.drive_on      = 1'b0;
            s.beep_counter  = 8'd0;
            s.alarm_counter = 16'd0;
            s.alarm_cycles  = 4'd0;
            s.alarm_phase   = PH_START;
        end
        nxt = s;
    end

endmodule

/* src/buzzer_alert_sequencer.sv */
// ----------------------------------------------------------------------------
// buzzer_alert_sequencer
// Prioritized buzzer alerts: key beep, confirm beep, test tone, low-battery
// alarm pattern and all-off beep, one tick per input item.
// ----------------------------------------------------------------------------
// Each accepted item is one timer tick. The block takes one item per clock
// cycle while s_axis_tready is high; its result appears in the output
// register on the cycle after acceptance and stays there until taken.
// s_axis_tready is high whenever the output register is empty or is being
// emptied in the same cycle, so a steady stream with m_axis_tready high flows
// at one item per cycle. Configuration writes take effect at once and should
// be made only while no item is in flight.
// ----------------------------------------------------------------------------
module buzzer_alert_sequencer
    import bas_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgWidth-1:0] cfg_wdata,
    // tick items
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [0] request_short_beep, [1] request_confirm_beep, [2] test_tone_active,
    // [3] request_low_battery, [4] request_all_off_beep, [5] burner_active,
    // [7:6] zero
    input  logic [7:0]          s_axis_tdata,
    // result items
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] buzzer_on, [2:1] tone_select, [3] clear_warning_enable,
    // [4] low_battery_pending, [7:5] zero
    output logic [7:0]          m_axis_tdata
);

    cfg_t   cfg_reg;
    state_t state_reg, state_next;
    tick_t  tick;
    logic   clear_pulse;
    logic   accept;
    logic   out_valid_reg, out_valid_next;
    logic [4:0] out_data_reg;

    assign tick = '{
        request_short_beep:   s_axis_tdata[0],
        request_confirm_beep: s_axis_tdata[1],
        test_tone_active:     s_axis_tdata[2],
        request_low_battery:  s_axis_tdata[3],
        request_all_off_beep: s_axis_tdata[4],
        burner_active:        s_axis_tdata[5]
    };

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bas_core u_core (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .tick        (tick),
        .nxt         (state_next),
        .clear_pulse (clear_pulse)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_beep_ticks   <= RST_SHORT_BEEP;
            cfg_reg.confirm_beep_ticks <= RST_CONFIRM_BEEP;
            cfg_reg.segment_ticks      <= RST_SEGMENT;
            cfg_reg.pause_ticks        <= RST_PAUSE;
            cfg_reg.alarm_repeats      <= RST_REPEATS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SHORT_BEEP:   cfg_reg.short_beep_ticks   <= cfg_wdata[7:0];
                REG_CONFIRM_BEEP: cfg_reg.confirm_beep_ticks <= cfg_wdata[7:0];
                REG_SEGMENT:      cfg_reg.segment_ticks      <= cfg_wdata;
                REG_PAUSE:        cfg_reg.pause_ticks        <= cfg_wdata;
                REG_REPEATS:      cfg_reg.alarm_repeats      <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with the item
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {state_next.low_battery_latched, clear_pulse,
                             state_next.drive_tone, state_next.drive_on};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg};

endmodule

/* src/bas_checker.sv */
// ----------------------------------------------------------------------------
// bas_checker
// Port-level checks of the buzzer alert sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "buzzer_alert_sequencer_assert.svh"

module bas_checker
    import bas_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                cfg_wr_en,
    input logic [CfgIdxW-1:0]  cfg_index,
    input logic [CfgWidth-1:0] cfg_wdata,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [7:0]          s_axis_tdata,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [7:0]          m_axis_tdata
);

    // the clear pulse only comes with the alarm latch dropping
    `BAS_ASSERT_IMP(a_clear_drops_latch, aclk, aresetn,
        m_axis_tvalid && m_axis_tdata[3], !m_axis_tdata[4])

    // an empty output register never stalls the input
    `BAS_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_axis_tvalid, s_axis_tready)

    // a stalled result holds
    `BAS_ASSERT_NXT(a_result_holds, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // reset empties the output register
    `BAS_ASSERT_NXT_ANY(a_reset_empty, aclk, !aresetn, !m_axis_tvalid)

endmodule

bind buzzer_alert_sequencer bas_checker u_bas_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for buzzer_alert_sequencer. Tick items are streamed in
// with random gaps while the result side stalls at random. A bit-accurate
// predictor of the alert priority, beep counters and low-battery pattern
// computes every expected result. A short directed script comes first. Random
// phases follow, each under its own register settings: minimum values, a few
// small settings, a random one, and finally the maximum values.
// ----------------------------------------------------------------------------
module tb;
    import bas_pkg::*;

    // result fields, lowest bit last
    typedef struct packed {
        logic       low_battery_pending;
        logic       clear_warning_enable;
        logic [1:0] tone_select;
        logic       buzzer_on;
    } buzz_out_t;

    typedef struct {
        logic [5:0] word;
        logic       typed;
        buzz_out_t  want;
    } script_row_t;

    // tick word bits, same order as s_axis_tdata
    localparam logic [5:0] K_IDLE    = 6'b000000;
    localparam logic [5:0] K_SHORT   = 6'b000001;
    localparam logic [5:0] K_CONFIRM = 6'b000010;
    localparam logic [5:0] K_TEST    = 6'b000100;
    localparam logic [5:0] K_LOWBAT  = 6'b001000;
    localparam logic [5:0] K_ALLOFF  = 6'b010000;
    localparam logic [5:0] K_BURNER  = 6'b100000;

    localparam int IDLE_PCT       = 34;
    localparam int STEADY_FIRST   = 300;
    localparam int STEADY_LAST    = 420;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 100000;
    localparam int NUM_PHASES     = 5;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgWidth-1:0] cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [7:0]          m_axis_tdata;

    buzzer_alert_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    state_t      bz;
    cfg_t        bz_cfg;
    buzz_out_t   tone_q[$];
    script_row_t script[$];
    cfg_t        plan_cfg[NUM_PHASES];
    int          plan_len[NUM_PHASES];
    int          n_sent;
    int          n_err;
    int          n_cycles;
    logic        tone_level;
    logic        burner_level;
    buzz_out_t   got_out;
    buzz_out_t   want_out;

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic logic steady();
        return n_sent >= STEADY_FIRST && n_sent < STEADY_LAST;
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void drive_buzzer(logic on, logic [1:0] tone);
        bz.drive_on = on;
        if (on) bz.drive_tone = tone;
    endfunction

    function automatic logic segment_over();
        bz.alarm_counter = bz.alarm_counter + 16'd1;
        if (bz.alarm_counter >= bz_cfg.segment_ticks) begin
            bz.alarm_counter = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one tick of the low-battery pattern; returns the clear-warning pulse
    function automatic logic alarm_step(logic burner);
        logic pulse;
        pulse = 1'b0;
        case (bz.alarm_phase)
            PH_START: begin
                drive_buzzer(1'b1, TONE_2K0);
                bz.alarm_phase   = PH_TONE1;
                bz.alarm_counter = '0;
            end
            PH_TONE1, PH_TONE2, PH_TONE3, PH_TONE4: begin
                if (segment_over()) begin
                    bz.drive_on    = 1'b0;
                    bz.alarm_phase = bz.alarm_phase + 4'd1;
                end
            end
            PH_GAP1, PH_GAP3: begin
                if (segment_over()) begin
                    drive_buzzer(1'b1, TONE_3K3);
                    bz.alarm_phase = bz.alarm_phase + 4'd1;
                end
            end
            PH_GAP2: begin
                if (segment_over()) begin
                    drive_buzzer(1'b1, TONE_4K1);
                    bz.alarm_phase = PH_TONE3;
                end
            end
            PH_PAUSE: begin
                bz.alarm_counter = bz.alarm_counter + 16'd1;
                if (bz.alarm_counter > bz_cfg.pause_ticks) begin
                    bz.alarm_counter = '0;
                    bz.alarm_phase   = PH_START;
                    bz.alarm_cycles  = bz.alarm_cycles + 4'd1;
                    if (bz.alarm_cycles > bz_cfg.alarm_repeats) begin
                        bz.alarm_cycles        = '0;
                        pulse                  = burner;
                        bz.low_battery_latched = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return pulse;
    endfunction

    function automatic buzz_out_t predict_tick(tick_t t);
        buzz_out_t o;
        logic      pulse;
        pulse = 1'b0;
        // latch requests before serving, so a pulse on a finishing tick is absorbed
        bz.short_beep_pending   = bz.short_beep_pending | t.request_short_beep;
        bz.confirm_beep_pending = bz.confirm_beep_pending | t.request_confirm_beep;
        bz.low_battery_latched  = bz.low_battery_latched | t.request_low_battery;
        bz.all_off_pending      = bz.all_off_pending | t.request_all_off_beep;

        if (bz.short_beep_pending) begin
            if (bz.beep_counter == 8'd0) drive_buzzer(1'b1, TONE_4K0);
            bz.beep_counter = bz.beep_counter + 8'd1;
            if (bz.beep_counter > bz_cfg.short_beep_ticks) begin
                bz.beep_counter       = '0;
                bz.drive_on           = 1'b0;
                bz.short_beep_pending = 1'b0;
            end
        end else if (bz.confirm_beep_pending) begin
            if (bz.beep_counter == 8'd0) drive_buzzer(1'b1, TONE_4K1);
            bz.beep_counter = bz.beep_counter + 8'd1;
            if (bz.beep_counter > bz_cfg.confirm_beep_ticks) begin
                bz.beep_counter         = '0;
                bz.drive_on             = 1'b0;
                bz.confirm_beep_pending = 1'b0;
            end
        end else if (t.test_tone_active) begin
            drive_buzzer(1'b1, TONE_4K1);
        end else if (bz.low_battery_latched) begin
            pulse = alarm_step(t.burner_active);
        end else if (bz.all_off_pending) begin
            if (bz.all_off_counter == 8'd0) drive_buzzer(1'b1, TONE_4K1);
            bz.all_off_counter = bz.all_off_counter + 8'd1;
            if (bz.all_off_counter > bz_cfg.confirm_beep_ticks) begin
                bz.all_off_counter = '0;
                bz.drive_on        = 1'b0;
                bz.all_off_pending = 1'b0;
            end
        end else begin
            // all-off counter and tone code are kept on idle
            bz.drive_on      = 1'b0;
            bz.beep_counter  = '0;
            bz.alarm_counter = '0;
            bz.alarm_cycles  = '0;
            bz.alarm_phase   = PH_START;
        end

        o.buzzer_on            = bz.drive_on;
        o.tone_select          = bz.drive_tone;
        o.clear_warning_enable = pulse;
        o.low_battery_pending  = bz.low_battery_latched;
        return o;
    endfunction

    function automatic tick_t word_to_tick(logic [5:0] w);
        tick_t t;
        t.request_short_beep   = w[0];
        t.request_confirm_beep = w[1];
        t.test_tone_active     = w[2];
        t.request_low_battery  = w[3];
        t.request_all_off_beep = w[4];
        t.burner_active        = w[5];
        return t;
    endfunction

    // mostly sparse request pulses over slowly changing levels, some noise
    function automatic logic [5:0] random_word();
        logic [5:0] w;
        if ($urandom_range(9) == 0) return 6'($urandom_range(63));
        if (tone_level) tone_level = ($urandom_range(3) != 0);
        else            tone_level = ($urandom_range(19) == 0);
        if ($urandom_range(9) == 0) burner_level = ~burner_level;
        w = K_IDLE;
        if ($urandom_range(24) == 0) w = w | K_SHORT;
        if ($urandom_range(24) == 0) w = w | K_CONFIRM;
        if ($urandom_range(19) == 0) w = w | K_LOWBAT;
        if ($urandom_range(19) == 0) w = w | K_ALLOFF;
        if (tone_level)   w = w | K_TEST;
        if (burner_level) w = w | K_BURNER;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_tick(logic [5:0] w, logic typed, buzz_out_t want);
        buzz_out_t predicted;
        @(negedge aclk);
        while (!steady() && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, w};
        do @(posedge aclk); while (!s_axis_tready);
        predicted = predict_tick(word_to_tick(w));
        tone_q.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    task automatic run_random(int count);
        repeat (count) send_tick(random_word(), 1'b0, '0);
    endtask

    // stop the stream and let every result come back
    task automatic settle();
        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (tone_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgWidth-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic write_settings(cfg_t c);
        write_reg(REG_SHORT_BEEP,   CfgWidth'(c.short_beep_ticks));
        write_reg(REG_CONFIRM_BEEP, CfgWidth'(c.confirm_beep_ticks));
        write_reg(REG_SEGMENT,      c.segment_ticks);
        write_reg(REG_PAUSE,        c.pause_ticks);
        write_reg(REG_REPEATS,      CfgWidth'(c.alarm_repeats));
        @(negedge aclk) cfg_wr_en <= 1'b0;
        bz_cfg = c;
    endtask

    function automatic void row(logic [5:0] w, logic typed, logic on, logic [1:0] tone,
                                logic lowbat);
        script_row_t r;
        r.word = w;
        r.typed = typed;
        r.want.buzzer_on            = on;
        r.want.tone_select          = tone;
        r.want.clear_warning_enable = 1'b0;
        r.want.low_battery_pending  = lowbat;
        script.push_back(r);
    endfunction

    // reset settings: key beep lasts three ticks, confirm beep 101
    function automatic void load_script();
        row(K_IDLE,                       1'b1, 1'b0, TONE_4K0, 1'b0);
        row(K_SHORT,                      1'b1, 1'b1, TONE_4K0, 1'b0);
        row(K_IDLE,                       1'b1, 1'b1, TONE_4K0, 1'b0);
        // repeated request on the finishing tick is swallowed
        row(K_SHORT,                      1'b1, 1'b0, TONE_4K0, 1'b0);
        row(K_IDLE,                       1'b1, 1'b0, TONE_4K0, 1'b0);
        row(K_TEST,                       1'b1, 1'b1, TONE_4K1, 1'b0);
        row(K_TEST | K_SHORT,             1'b1, 1'b1, TONE_4K0, 1'b0);
        row(K_TEST,                       1'b1, 1'b1, TONE_4K0, 1'b0);
        row(K_TEST,                       1'b1, 1'b0, TONE_4K0, 1'b0);
        row(K_TEST,                       1'b1, 1'b1, TONE_4K1, 1'b0);
        row(K_TEST | K_LOWBAT | K_BURNER, 1'b1, 1'b1, TONE_4K1, 1'b1);
        row(K_BURNER,                     1'b1, 1'b1, TONE_2K0, 1'b1);
        row(K_CONFIRM,                    1'b1, 1'b1, TONE_4K1, 1'b1);
        row(K_ALLOFF | K_BURNER,          1'b0, 1'b0, TONE_4K0, 1'b0);
        row(K_IDLE,                       1'b0, 1'b0, TONE_4K0, 1'b0);
        row(6'b111111,                    1'b0, 1'b0, TONE_4K0, 1'b0);
        row(K_SHORT,                      1'b0, 1'b0, TONE_4K0, 1'b0);
        row(K_TEST,                       1'b0, 1'b0, TONE_4K0, 1'b0);
        row(K_IDLE,                       1'b0, 1'b0, TONE_4K0, 1'b0);
    endfunction

    function automatic void load_plan();
        plan_cfg[0] = '{8'd0, 8'd0, 16'd0, 16'd0, 4'd0};
        plan_len[0] = 120;
        plan_cfg[1] = '{8'd1, 8'd3, 16'd2, 16'd3, 4'd1};
        plan_len[1] = 150;
        plan_cfg[2] = '{8'd3, 8'd5, 16'd1, 16'd5, 4'd2};
        plan_len[2] = 150;
        plan_cfg[3] = '{8'($urandom_range(6)), 8'($urandom_range(10)),
                        16'($urandom_range(4)), 16'($urandom_range(8)),
                        4'($urandom_range(3))};
        plan_len[3] = 100;
        // counters never reach these ends, so alerts run on to the end of the run
        plan_cfg[4] = '{8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 4'd15};
        plan_len[4] = 80;
    endfunction

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        n_sent        = 0;
        n_err         = 0;
        tone_level    = 1'b0;
        burner_level  = 1'b0;
        bz            = '0;
        bz_cfg        = '{RST_SHORT_BEEP, RST_CONFIRM_BEEP, RST_SEGMENT, RST_PAUSE,
                          RST_REPEATS};
        load_script();
        load_plan();
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (script[i]) send_tick(script[i].word, script[i].typed, script[i].want);
        run_random(60);
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_settings(plan_cfg[p]);
            run_random(plan_len[p]);
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_err == 0) $display("tb: PASS");
        else            $display("tb: FAIL");
        $finish;
    end

    // result side stalls, except in the steady window
    always @(negedge aclk) begin
        if (aresetn) m_axis_tready <= steady() || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            n_err++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_out = m_axis_tdata[4:0];
            if (tone_q.size() == 0) begin
                $display("%0t unexpected item: expected none actual %0h", $time, m_axis_tdata);
                n_err++;
            end else begin
                want_out = tone_q.pop_front();
                check_field("buzzer_on", 3'(want_out.buzzer_on), 3'(got_out.buzzer_on));
                check_field("tone_select", 3'(want_out.tone_select),
                            3'(got_out.tone_select));
                check_field("clear_warning_enable", 3'(want_out.clear_warning_enable),
                            3'(got_out.clear_warning_enable));
                check_field("low_battery_pending", 3'(want_out.low_battery_pending),
                            3'(got_out.low_battery_pending));
                check_field("pad", 3'b000, m_axis_tdata[7:5]);
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > TIMEOUT_CYCLES) begin
            $display("%0t timeout with %0d items outstanding", $time, tone_q.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial n_cycles = 0;

endmodule
